[src/fraction_reducer_macros.svh]
// ----------------------------------------------------------------------------
// fraction_reducer_macros: assertion macros
// Shared assertion wrappers for the fraction reducer checks.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_MACROS_SVH
`define FRACTION_REDUCER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fraction_reducer: check failed");

// Next-cycle implication, disabled while reset is held.
`define FR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fraction_reducer: check failed");

`endif

[src/fr_pkg.sv]
// ----------------------------------------------------------------------------
// fr_pkg: fraction reducer package
// Widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package fr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 * DATA_WIDTH + 3;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_FINISH
    } fr_state_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic scale;
        logic div_step;
        logic out_load;
    } fr_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic den_zero;
    } fr_status_t;

endpackage

[src/fr_datapath.sv]
// ----------------------------------------------------------------------------
// fr_datapath: fraction reducer datapath
// Magnitudes, binary gcd, two-lane restoring divider and result register.
// ----------------------------------------------------------------------------
module fr_datapath (
    input  logic                              aclk,
    input  logic [fr_pkg::DATA_WIDTH-1:0]     num_in,
    input  logic [fr_pkg::DATA_WIDTH-1:0]     den_in,
    input  fr_pkg::fr_cmd_t                   cmd,
    output fr_pkg::fr_status_t                status,
    output logic [fr_pkg::DATA_WIDTH-1:0]     gcd_out,
    output logic [fr_pkg::DATA_WIDTH-1:0]     num_mag,
    output logic [fr_pkg::DATA_WIDTH-1:0]     den_mag,
    output logic                              is_negative,
    output logic                              is_whole,
    output logic                              div_error
);
    import fr_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W-1:0]     nm_reg, dm_reg;
    logic             neg_reg;
    logic [W-1:0]     a_reg, b_reg, a_next, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [W-1:0]     g_reg;
    logic [W:0]       remn_reg, remd_reg;
    logic [W-1:0]     qn_reg, qd_reg;
    logic [2*W:0]     lane_n, lane_d;
    logic [W-1:0]     nm_load, dm_load;

    logic [W-1:0]     gcd_out_reg, num_out_reg, den_out_reg;
    logic             neg_out_reg, whole_out_reg, err_out_reg;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
        return x[W-1] ? (~x + W'(1)) : x;
    endfunction

    // One restoring step: returns {remainder, quotient}.
    function automatic logic [2*W:0] div_bit(input logic [W:0] rem,
                                             input logic [W-1:0] q,
                                             input logic [W-1:0] d);
        logic [W:0] rs;
        logic       take;
        rs   = {rem[W-1:0], q[W-1]};
        take = (rs >= {1'b0, d});
        return {take ? (rs - {1'b0, d}) : rs, q[W-2:0], take};
    endfunction

    assign nm_load = mag_of(num_in);
    assign dm_load = mag_of(den_in);

    assign status.gcd_done = (a_reg == '0) || (b_reg == '0);
    assign status.den_zero = (dm_reg == '0);

    // Binary gcd step: strip shared twos, halve the even side, subtract odd pairs.
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (!a_reg[0] && !b_reg[0]) begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + CNT_W'(1);
        end else if (!a_reg[0]) begin
            a_next = a_reg >> 1;
        end else if (!b_reg[0]) begin
            b_next = b_reg >> 1;
        end else if (a_reg >= b_reg) begin
            a_next = (a_reg - b_reg) >> 1;
        end else begin
            b_next = (b_reg - a_reg) >> 1;
        end
    end

    assign lane_n = div_bit(remn_reg, qn_reg, g_reg);
    assign lane_d = div_bit(remd_reg, qd_reg, g_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            nm_reg  <= nm_load;
            dm_reg  <= dm_load;
            neg_reg <= num_in[W-1] ^ den_in[W-1];
            a_reg   <= nm_load;
            b_reg   <= dm_load;
            k_reg   <= '0;
        end else if (cmd.gcd_step) begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end
        if (cmd.scale) begin
            g_reg    <= (a_reg | b_reg) << k_reg;
            remn_reg <= '0;
            remd_reg <= '0;
            qn_reg   <= nm_reg;
            qd_reg   <= dm_reg;
        end else if (cmd.div_step) begin
            remn_reg <= lane_n[2*W:W];
            qn_reg   <= lane_n[W-1:0];
            remd_reg <= lane_d[2*W:W];
            qd_reg   <= lane_d[W-1:0];
        end
        if (cmd.out_load) begin
            err_out_reg   <= (dm_reg == '0);
            gcd_out_reg   <= (dm_reg == '0) ? '0 : g_reg;
            num_out_reg   <= (dm_reg == '0) ? '0 : qn_reg;
            den_out_reg   <= (dm_reg == '0) ? '0 : qd_reg;
            neg_out_reg   <= (dm_reg != '0) && neg_reg && (nm_reg != '0);
            whole_out_reg <= (dm_reg != '0) && (qd_reg == W'(1));
        end
    end

    assign gcd_out     = gcd_out_reg;
    assign num_mag     = num_out_reg;
    assign den_mag     = den_out_reg;
    assign is_negative = neg_out_reg;
    assign is_whole    = whole_out_reg;
    assign div_error   = err_out_reg;

endmodule

[src/fr_ctrl.sv]
// ----------------------------------------------------------------------------
// fr_ctrl: fraction reducer controller
// Sequences load, gcd, scaling, division and the output hand-off.
// ----------------------------------------------------------------------------
module fr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  fr_pkg::fr_status_t status,
    output fr_pkg::fr_cmd_t    cmd
);
    import fr_pkg::*;

    fr_state_t        state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (status.den_zero) begin
                    state_next = ST_FINISH;
                end else if (status.gcd_done) begin
                    cmd.scale  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[src/fraction_reducer.sv]
// ----------------------------------------------------------------------------
// fraction_reducer: reduces a signed fraction to lowest terms
// Top level joining the controller and the datapath on stream ports.
// ----------------------------------------------------------------------------
// Each input word carries a signed numerator and denominator; each output
// word gives their gcd, the reduced magnitudes and three flags. One word is
// worked on at a time: up to 2*DATA_WIDTH binary-gcd steps, then
// DATA_WIDTH restoring-division steps that form both quotients side by
// side. A zero denominator skips both. The result sits in an output
// register, so the next word is taken while the previous one waits for
// m_tready.
module fraction_reducer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: num_in [31:0], den_in [63:32]
    input  logic [fr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: gcd_out [31:0], num_mag [63:32], den_mag [95:64],
    //          is_negative [96], is_whole [97], div_error [98], zero pad above
    output logic [fr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fr_pkg::*;

    fr_cmd_t                cmd;
    fr_status_t             status;
    logic [DATA_WIDTH-1:0]  gcd_out, num_mag, den_mag;
    logic                   is_negative, is_whole, div_error;

    // sequence the work; accept only from idle
    fr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // split the input word straight into the datapath load
    fr_datapath u_datapath (
        .aclk        (aclk),
        .num_in      (s_tdata[DATA_WIDTH-1:0]),
        .den_in      (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .cmd         (cmd),
        .status      (status),
        .gcd_out     (gcd_out),
        .num_mag     (num_mag),
        .den_mag     (den_mag),
        .is_negative (is_negative),
        .is_whole    (is_whole),
        .div_error   (div_error)
    );

    // pack the result fields, first field lowest, zero-padded to whole bytes
    assign m_tdata = M_TDATA_W'({div_error, is_whole, is_negative,
                                 den_mag, num_mag, gcd_out});

    `include "fraction_reducer_macros.svh"

    // an accepted word blocks intake until its result has been handed on
    `FR_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // an error result carries nothing but the flag
    `FR_ASSERT_NOW(a_error_clean, aclk, aresetn, m_tvalid && div_error, (gcd_out == '0) && (num_mag == '0) && (den_mag == '0) && !is_whole && !is_negative)
    // a good result always has a nonzero denominator and gcd
    `FR_ASSERT_NOW(a_den_nonzero, aclk, aresetn, m_tvalid && !div_error, (den_mag != '0) && (gcd_out != '0))
    // whole flag tracks a unit denominator
    `FR_ASSERT_NOW(a_whole_flag, aclk, aresetn, m_tvalid && !div_error, is_whole == (den_mag == DATA_WIDTH'(1)))

endmodule

[tb/sv/tb_fraction_reducer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fraction_reducer: self-checking bench for the fraction reducer
// Drives signed numerator/denominator words into the stream input, predicts
// the gcd, reduced magnitudes and flags of each word, and checks every output
// word in order. A directed set of edge cases runs first, then random words
// under four flow-control phases on both sides of the block.
// ----------------------------------------------------------------------------
module tb_fraction_reducer;

    import fr_pkg::*;

    localparam int DW          = DATA_WIDTH;
    localparam int RAND_WORDS  = 135;           // random words in each phase
    localparam int N_PHASES    = 4;
    localparam int TAIL_CYCLES = 3 * DW + 20;   // longest word plus margin
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [DW-1:0] gcd_out;
        logic [DW-1:0] num_mag;
        logic [DW-1:0] den_mag;
        logic          is_negative;
        logic          is_whole;
        logic          div_error;
    } fr_result_t;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } fr_pair_t;

    // A directed row carries its answer only where it is plain from the inputs.
    typedef struct packed {
        fr_pair_t   pair;
        logic       typed;
        fr_result_t want;
    } dir_row_t;

    localparam fr_result_t NO_ANSWER = '0;
    localparam int N_DIR = 24;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // zero denominator: error flag alone
        '{'{32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
        '{'{32'h0000_0005, 32'h0000_0000}, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
        '{'{32'h8000_0000, 32'h0000_0000}, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
        '{'{32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
        // zero numerator: gcd is |den|, result 0/1, never negative
        '{'{32'h0000_0000, 32'h0000_0007}, 1'b1,
          '{32'h0000_0007, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0}},
        '{'{32'h0000_0000, 32'hFFFF_FFF9}, 1'b1,
          '{32'h0000_0007, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0}},
        '{'{32'h0000_0000, 32'h8000_0000}, 1'b1,
          '{32'h8000_0000, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0}},
        '{'{32'h0000_0000, 32'h7FFF_FFFF}, 1'b1,
          '{32'h7FFF_FFFF, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0}},
        // most negative and most positive values
        '{'{32'h8000_0000, 32'h8000_0000}, 1'b1,
          '{32'h8000_0000, 32'd1, 32'd1, 1'b0, 1'b1, 1'b0}},
        '{'{32'h8000_0000, 32'h0000_0001}, 1'b1,
          '{32'd1, 32'h8000_0000, 32'd1, 1'b1, 1'b1, 1'b0}},
        '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1,
          '{32'h7FFF_FFFF, 32'd1, 32'd1, 1'b0, 1'b1, 1'b0}},
        '{'{32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
          '{32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0}},
        // unit magnitudes, every sign combination
        '{'{32'h0000_0001, 32'h0000_0001}, 1'b1, '{32'd1, 32'd1, 32'd1, 1'b0, 1'b1, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'd1, 32'd1, 32'd1, 1'b0, 1'b1, 1'b0}},
        '{'{32'h0000_0001, 32'hFFFF_FFFF}, 1'b1, '{32'd1, 32'd1, 32'd1, 1'b1, 1'b1, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h0000_0001}, 1'b1, '{32'd1, 32'd1, 32'd1, 1'b1, 1'b1, 1'b0}},
        // ordinary reductions, left to the predictor
        '{'{32'h0000_000C, 32'h0000_0012}, 1'b0, NO_ANSWER},
        '{'{32'hFFFF_FFF4, 32'h0000_0012}, 1'b0, NO_ANSWER},
        '{'{32'h0000_0024, 32'hFFFF_FFF4}, 1'b0, NO_ANSWER},
        '{'{32'hFFFF_FFFF, 32'h8000_0000}, 1'b0, NO_ANSWER},
        '{'{32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, NO_ANSWER},
        '{'{32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, NO_ANSWER},
        '{'{32'h0000_03E8, 32'h0000_0007}, 1'b0, NO_ANSWER},
        '{'{32'h4000_0000, 32'h0001_0000}, 1'b0, NO_ANSWER}
    };

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata: num_in [31:0], den_in [63:32]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata: gcd_out [31:0], num_mag [63:32], den_mag [95:64],
    //          is_negative [96], is_whole [97], div_error [98], zero pad above
    logic [M_TDATA_W-1:0] m_tdata;

    fr_result_t pending_reductions [$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int n_div_error = 0;
    int n_zero_num = 0;
    int n_whole = 0;
    int n_negative = 0;
    int cycle_count = 0;

    fraction_reducer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Predict one output word: Euclid on the magnitudes, then both quotients.
    function automatic fr_result_t reduce_fraction(logic [DW-1:0] n, logic [DW-1:0] d);
        fr_result_t    res;
        logic [DW-1:0] nm;
        logic [DW-1:0] dm;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] r;
        res = '0;
        // two's complement negation wraps the most negative value onto itself,
        // which is exactly its unsigned magnitude
        nm = n[DW-1] ? (~n + 1'b1) : n;
        dm = d[DW-1] ? (~d + 1'b1) : d;
        if (dm == '0) begin
            res.div_error = 1'b1;
            return res;
        end
        if (nm == '0) begin
            res.gcd_out  = dm;
            res.den_mag  = DW'(1);
            res.is_whole = 1'b1;
            return res;
        end
        a = nm;
        b = dm;
        while (b != '0) begin
            r = a % b;
            a = b;
            b = r;
        end
        res.gcd_out     = a;
        res.num_mag     = nm / a;
        res.den_mag     = dm / a;
        res.is_negative = n[DW-1] ^ d[DW-1];
        res.is_whole    = (res.den_mag == 1);
        return res;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_pair(fr_pair_t pr);
        logic [S_TDATA_W-1:0] v;
        v = '0;
        v[DW-1:0]    = pr.num;
        v[2*DW-1:DW] = pr.den;
        return v;
    endfunction

    function automatic fr_result_t unpack_result(logic [M_TDATA_W-1:0] v);
        fr_result_t res;
        res.gcd_out     = v[DW-1:0];
        res.num_mag     = v[2*DW-1:DW];
        res.den_mag     = v[3*DW-1:2*DW];
        res.is_negative = v[3*DW];
        res.is_whole    = v[3*DW+1];
        res.div_error   = v[3*DW+2];
        return res;
    endfunction

    function automatic logic [DW-1:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mix of fraction shapes: words with real common factors so the gcd search
    // and both divisions do deep work, plus random words and the special cases.
    function automatic fr_pair_t random_fraction();
        fr_pair_t      pr;
        logic [DW-1:0] k;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        k = $urandom_range(1, 65535);
        case ($urandom_range(9))
            0, 1: begin
                pr.num = $urandom;
                pr.den = $urandom;
            end
            2, 3: begin
                a = $urandom_range(0, 32767);
                b = $urandom_range(1, 32767);
                pr.num = a * k;
                pr.den = b * k;
            end
            4: begin
                pr.num = $urandom_range(0, 255);
                pr.den = $urandom_range(1, 255);
            end
            5: begin
                // whole result: numerator a multiple of the denominator
                b = $urandom_range(1, 4095);
                pr.den = b;
                pr.num = b * $urandom_range(0, 262143);
            end
            6: begin
                pr.num = '0;
                pr.den = $urandom;
            end
            7: begin
                pr.num = $urandom;
                pr.den = '0;
            end
            8: begin
                pr.num = pick_extreme();
                pr.den = $urandom_range(1) ? pick_extreme() : $urandom;
            end
            default: begin
                pr.num = 32'd1 << $urandom_range(31);
                pr.den = 32'd1 << $urandom_range(31);
            end
        endcase
        if ($urandom_range(1)) pr.num = ~pr.num + 1'b1;
        if ($urandom_range(1)) pr.den = ~pr.den + 1'b1;
        return pr;
    endfunction

    // Offer one word, idling first at the phase's rate; hold tvalid until it
    // is taken, then queue its expected result.
    task automatic offer_word(input fr_pair_t pr, input logic typed, input fr_result_t want);
        fr_result_t res;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pair(pr);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = typed ? want : reduce_fraction(pr.num, pr.den);
        pending_reductions = {pending_reductions, res};
        words_sent++;
        n_div_error += res.div_error;
        n_whole     += res.is_whole;
        n_negative  += res.is_negative;
        if (pr.num == '0 && pr.den != '0) n_zero_num++;
    endtask

    // Drop tvalid and hold off until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_reductions.size() != 0) @(posedge aclk);
    endtask

    // Receiver: stall at the phase's rate, one decision per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted output word with the oldest expectation.
    always @(posedge aclk) begin
        fr_result_t got;
        fr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (pending_reductions.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected output word: %p", $realtime, got);
            end else begin
                want = pending_reductions.pop_front();
                words_checked++;
                if (got.gcd_out !== want.gcd_out || got.num_mag !== want.num_mag ||
                    got.den_mag !== want.den_mag || got.is_negative !== want.is_negative ||
                    got.is_whole !== want.is_whole || got.div_error !== want.div_error) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] mismatch on word %0d", $realtime, words_checked);
                        $display("    expected gcd=%h num=%h den=%h neg=%b whole=%b err=%b",
                                 want.gcd_out, want.num_mag, want.den_mag,
                                 want.is_negative, want.is_whole, want.div_error);
                        $display("    actual   gcd=%h num=%h den=%h neg=%b whole=%b err=%b",
                                 got.gcd_out, got.num_mag, got.den_mag,
                                 got.is_negative, got.is_whole, got.div_error);
                    end
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_reductions.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // phase 0: free flow; 1: sender idles; 2: receiver stalls; 3: both
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 62; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 62; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            if (ph == 0) begin
                for (int i = 0; i < N_DIR; i++)
                    offer_word(DIR_ROWS[i].pair, DIR_ROWS[i].typed, DIR_ROWS[i].want);
            end
            for (int i = 0; i < RAND_WORDS; i++)
                offer_word(random_fraction(), 1'b0, NO_ANSWER);
            // hold the sender back until the block has caught up
            drain_results();
        end

        // let any spurious late word show itself
        repeat (TAIL_CYCLES) @(posedge aclk);
        mismatches += pending_reductions.size();

        $display("covered %0d words over %0d flow-control phases, %0d checked",
                 words_sent, N_PHASES, words_checked);
        $display("  %0d zero denominators, %0d zero numerators, %0d whole, %0d negative",
                 n_div_error, n_zero_num, n_whole, n_negative);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/fr_pkg.sv
src/fr_datapath.sv
src/fr_ctrl.sv
src/fraction_reducer.sv
tb/sv/tb_fraction_reducer.sv
